// ===== design/tsli_pkg.sv =====
// Package for the timestamped sample interpolation unit.
// Holds request and status codes and the controller/datapath link types.
// No dependencies.
package tsli_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // Response status carried on rsp_tuser.
   localparam logic [1:0] ST_INTERP  = 2'd0;
   localparam logic [1:0] ST_EXACT   = 2'd1;
   localparam logic [1:0] ST_FEW     = 2'd2;
   localparam logic [1:0] ST_OUTSIDE = 2'd3;

   // Sample memory read address selection.
   localparam logic [2:0] RD_FIRST = 3'd0;
   localparam logic [2:0] RD_LAST  = 3'd1;
   localparam logic [2:0] RD_MID   = 3'd2;
   localparam logic [2:0] RD_LO    = 3'd3;
   localparam logic [2:0] RD_LOM1  = 3'd4;

   localparam int TIME_W = 48;
   localparam int AXIS_W = 32;
   localparam int AXES   = 6;
   localparam int FRAC_W = 16;
   localparam int DEFAULT_RING_DEPTH = 64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       push;
      logic       clear;
      logic       load_stamp;
      logic [2:0] rd_sel;
      logic       cap_first;
      logic       srch_init;
      logic       srch_upd;
      logic       cap_front;
      logic       cap_back;
      logic       div_step;
      logic       mul_step;
      logic       emit_rd;
      logic       emit_front;
      logic       set_err;
      logic [1:0] err_code;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic few_samples;
      logic span_bad;
      logic srch_done;
      logic lo_zero;
      logic lo_end;
      logic direct;
      logic div_last;
      logic mul_last;
   } stat_type;

endpackage

// ===== design/tsli_ctrl.sv =====
// Controller state machine of the timestamped sample interpolation unit.
// Sequences push, clear and query requests; depends on tsli_pkg.
module tsli_ctrl import tsli_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDF    = 4'd1;
   localparam logic [3:0] S_RDL    = 4'd2;
   localparam logic [3:0] S_CHK    = 4'd3;
   localparam logic [3:0] S_SA     = 4'd4;
   localparam logic [3:0] S_SB     = 4'd5;
   localparam logic [3:0] S_FRONT  = 4'd6;
   localparam logic [3:0] S_BACK   = 4'd7;
   localparam logic [3:0] S_PREP   = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_MUL    = 4'd10;
   localparam logic [3:0] S_LOADRD = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_FIRST;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  FUNC_PUSH:  cmd.push = 1'b1;
                  FUNC_CLEAR: cmd.clear = 1'b1;
                  FUNC_QUERY: begin
                     cmd.load_stamp = 1'b1;
                     if (stat.few_samples) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_FEW;
                        state_in     = S_OUT;
                     end else begin
                        state_in = S_RDF;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RDF: begin
            cmd.rd_sel = RD_FIRST;
            state_in   = S_RDL;
         end
         S_RDL: begin
            cmd.cap_first = 1'b1;
            cmd.rd_sel    = RD_LAST;
            state_in      = S_CHK;
         end
         S_CHK: begin
            if (stat.span_bad) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = ST_OUTSIDE;
               state_in     = S_OUT;
            end else begin
               cmd.srch_init = 1'b1;
               state_in      = S_SA;
            end
         end
         S_SA: begin
            cmd.rd_sel = RD_MID;
            state_in   = stat.srch_done ? S_FRONT : S_SB;
         end
         S_SB: begin
            cmd.srch_upd = 1'b1;
            state_in     = S_SA;
         end
         S_FRONT: begin
            if (stat.lo_zero) begin
               cmd.rd_sel = RD_FIRST;
               state_in   = S_LOADRD;
            end else if (stat.lo_end) begin
               cmd.rd_sel = RD_LAST;
               state_in   = S_LOADRD;
            end else begin
               cmd.rd_sel = RD_LO;
               state_in   = S_BACK;
            end
         end
         S_BACK: begin
            cmd.cap_front = 1'b1;
            cmd.rd_sel    = RD_LOM1;
            state_in      = S_PREP;
         end
         S_PREP: begin
            cmd.cap_back = 1'b1;
            if (stat.direct) begin
               cmd.emit_front = 1'b1;
               state_in       = S_OUT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (stat.mul_last) state_in = S_OUT;
         end
         S_LOADRD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/tsli_dpath.sv =====
// Datapath of the timestamped sample interpolation unit: sample memory,
// ring pointers, search bounds, fraction divider and interpolator. Uses tsli_pkg.
module tsli_dpath import tsli_pkg::*; #(
   parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [TIME_W-1:0]        in_stamp,
   input  logic [AXES*AXIS_W-1:0]   in_axes,
   output logic [1:0]               out_status,
   output logic [AXES*AXIS_W-1:0]   out_axes
);

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int MEM_W  = TIME_W + AXES * AXIS_W;
   localparam logic [CNT_W:0] DEPTH_V = (CNT_W + 1)'(RING_DEPTH);

   logic [MEM_W-1:0]  mem [RING_DEPTH];
   logic [MEM_W-1:0]  rd_ff;
   logic [SLOT_W-1:0] oldest_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [TIME_W-1:0] stamp_ff, tfirst_ff, tfront_ff, dt_ff, rem_ff;
   logic [CNT_W-1:0]  lo_ff, hi_ff;
   logic [FRAC_W-1:0] quot_ff;
   logic [3:0]        step_ff;
   logic [2:0]        idx_ff;
   logic [AXIS_W-1:0] front_ff [AXES];
   logic [AXIS_W-1:0] back_ff  [AXES];
   logic [AXIS_W-1:0] res_ff   [AXES];
   logic [1:0]        status_ff;

   // Ring slot of a logical sample index.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0] logical);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(logical);
      if (sum >= DEPTH_V) sum = sum - DEPTH_V;
      return sum[SLOT_W-1:0];
   endfunction

   logic [TIME_W-1:0] rd_time;
   logic [CNT_W:0]    mid_w;
   logic [CNT_W-1:0]  mid;
   logic [CNT_W-1:0]  rd_logical;
   logic [SLOT_W-1:0] rd_addr, push_slot;
   logic              full;

   assign rd_time = rd_ff[TIME_W-1:0];
   assign mid_w   = ((CNT_W + 1)'(lo_ff) + (CNT_W + 1)'(hi_ff)) >> 1;
   assign mid     = mid_w[CNT_W-1:0];
   assign full    = (fill_ff >= CNT_W'(RING_DEPTH));

   // Read address selection.
   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_logical = '0;
         RD_LAST:  rd_logical = fill_ff - CNT_W'(1);
         RD_MID:   rd_logical = mid;
         RD_LO:    rd_logical = lo_ff;
         RD_LOM1:  rd_logical = lo_ff - CNT_W'(1);
         default:  rd_logical = '0;
      endcase
   end
   assign rd_addr   = slot_of(oldest_ff, rd_logical);
   assign push_slot = full ? oldest_ff : slot_of(oldest_ff, fill_ff);

   // Sample memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) mem[push_slot] <= {in_axes, in_stamp};
      rd_ff <= mem[rd_addr];
   end

   // Ring pointers.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         oldest_ff <= '0;
         fill_ff   <= '0;
      end else if (cmd.push) begin
         if (full) begin
            oldest_ff <= slot_of(oldest_ff, CNT_W'(1));
         end else begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
      end
   end

   // Bracket evaluation from the captured front and the back just read.
   logic [TIME_W-1:0] dt_w, num_w;
   assign dt_w = tfront_ff - rd_time;
   always_comb begin
      num_w = (stamp_ff > rd_time) ? (stamp_ff - rd_time) : '0;
      if (num_w >= dt_w) num_w = dt_w - TIME_W'(1);
   end

   // Divider step: one quotient bit per cycle.
   logic [TIME_W:0] rem2_w;
   logic            ge_w;
   assign rem2_w = {rem_ff, 1'b0};
   assign ge_w   = (rem2_w >= {1'b0, dt_ff});

   // Interpolation of one axis per cycle.
   logic signed [AXIS_W:0]          diff_w;
   logic signed [AXIS_W+FRAC_W+1:0] prod_w;
   logic signed [AXIS_W+FRAC_W+1:0] rnd_w;
   logic [AXIS_W-1:0]               interp_w;
   logic [FRAC_W-1:0]               frac_w;
   assign frac_w = quot_ff;
   assign diff_w = $signed({front_ff[idx_ff][AXIS_W-1], front_ff[idx_ff]})
                 - $signed({back_ff[idx_ff][AXIS_W-1], back_ff[idx_ff]});
   assign prod_w = diff_w * $signed({1'b0, frac_w});
   assign rnd_w  = (prod_w + (AXIS_W + FRAC_W + 2)'(1 << (FRAC_W - 1))) >>> FRAC_W;
   assign interp_w = back_ff[idx_ff] + rnd_w[AXIS_W-1:0];

   // Query registers.
   always_ff @(posedge clock) begin
      if (cmd.load_stamp) stamp_ff <= in_stamp;
      if (cmd.cap_first)  tfirst_ff <= rd_time;
      if (cmd.srch_init) begin
         lo_ff <= '0;
         hi_ff <= fill_ff;
      end
      if (cmd.srch_upd) begin
         if (rd_time < stamp_ff) begin
            lo_ff <= mid + CNT_W'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.cap_front) begin
         tfront_ff <= rd_time;
         for (int a = 0; a < AXES; a++) front_ff[a] <= rd_ff[TIME_W + a*AXIS_W +: AXIS_W];
      end
      if (cmd.cap_back) begin
         for (int a = 0; a < AXES; a++) back_ff[a] <= rd_ff[TIME_W + a*AXIS_W +: AXIS_W];
         dt_ff   <= dt_w;
         rem_ff  <= num_w;
         quot_ff <= '0;
         step_ff <= '0;
         idx_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= ge_w ? TIME_W'(rem2_w - {1'b0, dt_ff}) : rem2_w[TIME_W-1:0];
         quot_ff <= {quot_ff[FRAC_W-2:0], ge_w};
         step_ff <= step_ff + 4'd1;
      end
      if (cmd.mul_step) begin
         res_ff[idx_ff] <= interp_w;
         idx_ff         <= idx_ff + 3'd1;
         status_ff      <= ST_INTERP;
      end
      if (cmd.set_err) begin
         status_ff <= cmd.err_code;
         for (int a = 0; a < AXES; a++) res_ff[a] <= '0;
      end
      if (cmd.emit_rd) begin
         status_ff <= ST_EXACT;
         for (int a = 0; a < AXES; a++) res_ff[a] <= rd_ff[TIME_W + a*AXIS_W +: AXIS_W];
      end
      if (cmd.emit_front) begin
         status_ff <= ST_EXACT;
         for (int a = 0; a < AXES; a++) res_ff[a] <= front_ff[a];
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.few_samples = (fill_ff < CNT_W'(2));
      stat.span_bad    = (stamp_ff < tfirst_ff) || (stamp_ff > rd_time);
      stat.srch_done   = (lo_ff >= hi_ff);
      stat.lo_zero     = (lo_ff == '0);
      stat.lo_end      = (lo_ff >= fill_ff);
      stat.direct      = (tfront_ff == stamp_ff) || (tfront_ff <= rd_time);
      stat.div_last    = (step_ff == 4'd15);
      stat.mul_last    = (idx_ff == 3'(AXES - 1));
   end

   assign out_status = status_ff;
   always_comb begin
      for (int a = 0; a < AXES; a++) out_axes[a*AXIS_W +: AXIS_W] = res_ff[a];
   end

endmodule

// ===== design/timestamped_sample_linear_interp_unit.sv =====
// Top level of the timestamped sample interpolation unit.
// Instantiates tsli_ctrl and tsli_dpath; uses tsli_pkg.
//
// Usage: requests arrive on the req_ stream. req_tuser selects push,
// query or clear; req_tdata carries the timestamp and six Q16.16 axes.
// Push and clear give no response. A query gives one response on the
// rsp_ stream: rsp_tuser carries the status, rsp_tdata the six axes
// (zero on an error status).
// An in-span query runs a binary search over the n buffered samples through
// the single read port of the sample memory. An interpolated result then
// passes the serial fraction divider, which yields 16 quotient bits, and
// the shared multiplier handling one axis per cycle; errors and exact
// hits skip both.
// One request is in flight at a time; req_tready is low until the response
// is taken. While the receiver stalls, the response holds on rsp_tdata.
// Reset empties the ring; the memory itself is not cleared.
module timestamped_sample_linear_interp_unit import tsli_pkg::*; #(
   parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // stamp[47:0], in_acc_x, in_acc_y, in_acc_z, in_gyro_x, in_gyro_y, in_gyro_z
   input  logic [239:0] req_tdata,
   // func
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_acc_x[31:0], out_acc_y, out_acc_z, out_gyro_x, out_gyro_y, out_gyro_z
   output logic [191:0] rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;

   // Request sequencing.
   tsli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   tsli_dpath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_stamp   (req_tdata[TIME_W-1:0]),
      .in_axes    (req_tdata[TIME_W +: AXES*AXIS_W]),
      .out_status (rsp_tuser),
      .out_axes   (rsp_tdata)
   );

endmodule

// ===== sim/timestamped_sample_linear_interp_unit_tb.sv =====
// Testbench for the timestamped sample interpolation unit.
// Drives push, query and clear requests and checks each response against a built-in predictor.
// Depends on tsli_pkg and timestamped_sample_linear_interp_unit.
module timestamped_sample_linear_interp_unit_tb;
   import tsli_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEFAULT_RING_DEPTH;

   typedef logic [AXIS_W-1:0] axes_type [AXES];

   typedef struct {
      logic [1:0]  status;
      axes_type    axis;
   } answer_type;

   // Predictor of the sample ring plus the queue of expected responses.
   class interp_scoreboard;
      logic [TIME_W-1:0] stamp_ring [DEPTH];
      logic [AXIS_W-1:0] axis_ring [AXES][DEPTH];
      int unsigned       head;
      int unsigned       count;
      answer_type        pending [$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       status_seen [4];

      function void reset_state();
         head = 0;
         count = 0;
      endfunction

      function int unsigned slot(int unsigned i);
         return (head + i) % DEPTH;
      endfunction

      // Append one expected response at the tail of the queue.
      function void queue_answer(answer_type a);
         pending.insert(pending.size(), a);
      endfunction

      function void take_sample(ref answer_type a, input int unsigned i, logic [1:0] st);
         int unsigned s;
         s = slot(i);
         a.status = st;
         for (int k = 0; k < AXES; k++) a.axis[k] = axis_ring[k][s];
      endfunction

      // Note an accepted request and predict its response, if any.
      function void note_request(logic [1:0] func, logic [TIME_W-1:0] stamp, axes_type v);
         answer_type a;
         int unsigned s, lo, hi, mid, sb, sf;
         logic [63:0] tb, tf, num, dt, frac, ub, uf, acc;
         if (func == FUNC_PUSH) begin
            if (count >= DEPTH) begin
               s = head;
               head = (head + 1) % DEPTH;
            end else begin
               s = slot(count);
               count++;
            end
            stamp_ring[s] = stamp;
            for (int k = 0; k < AXES; k++) axis_ring[k][s] = v[k];
            return;
         end
         if (func == FUNC_CLEAR) begin
            reset_state();
            return;
         end
         if (func != FUNC_QUERY) return;
         a.status = ST_FEW;
         for (int k = 0; k < AXES; k++) a.axis[k] = '0;
         if (count < 2) begin
            queue_answer(a);
            return;
         end
         if (stamp < stamp_ring[slot(0)] || stamp > stamp_ring[slot(count - 1)]) begin
            a.status = ST_OUTSIDE;
            queue_answer(a);
            return;
         end
         lo = 0;
         hi = count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (stamp_ring[slot(mid)] < stamp) lo = mid + 1;
            else hi = mid;
         end
         if (lo == 0) take_sample(a, 0, ST_EXACT);
         else if (lo >= count) take_sample(a, count - 1, ST_EXACT);
         else begin
            sf = slot(lo);
            sb = slot(lo - 1);
            tf = stamp_ring[sf];
            tb = stamp_ring[sb];
            if (tf == stamp || tf <= tb) take_sample(a, lo, ST_EXACT);
            else begin
               dt = tf - tb;
               num = (stamp > tb) ? stamp - tb : 0;
               if (num >= dt) num = dt - 1;
               frac = (num << 16) / dt;
               if (frac > 65535) frac = 65535;
               a.status = ST_INTERP;
               // Offset binary keeps the weighted sum unsigned.
               for (int k = 0; k < AXES; k++) begin
                  ub = {32'd0, axis_ring[k][sb] ^ 32'h8000_0000};
                  uf = {32'd0, axis_ring[k][sf] ^ 32'h8000_0000};
                  acc = ub * (64'd65536 - frac) + uf * frac + 64'd32768;
                  a.axis[k] = acc[47:16] ^ 32'h8000_0000;
               end
            end
         end
         queue_answer(a);
      endfunction

      // Compare one response with the oldest expectation.
      function void check_response(logic [1:0] st, logic [191:0] data);
         answer_type a;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response status %0d", $realtime, st);
            errors++;
            return;
         end
         a = pending.pop_front();
         status_seen[a.status]++;
         if (st !== a.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, a.status, st);
            errors++;
         end
         for (int k = 0; k < AXES; k++)
            if (data[k*AXIS_W +: AXIS_W] !== a.axis[k]) begin
               $display("%0t: axis %0d expected %h actual %h", $realtime, k, a.axis[k],
                        data[k*AXIS_W +: AXIS_W]);
               errors++;
            end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [239:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   interp_scoreboard board = new();
   logic             stim_done = 1'b0;
   int unsigned      cycles = 0;
   int unsigned      requests = 0;
   logic [TIME_W-1:0] now_us = '0;

   timestamped_sample_linear_interp_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Random gap length: mostly short, now and then long.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Send one request and wait for its acceptance; valid drops only for a gap.
   task automatic send_request(logic [1:0] func, logic [TIME_W-1:0] stamp, axes_type v);
      int unsigned g;
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tuser <= func;
      req_tdata <= {v[5], v[4], v[3], v[2], v[1], v[0], stamp};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(func, stamp, v);
      requests++;
      @(negedge clock);
   endtask

   task automatic push_sample(logic [TIME_W-1:0] stamp);
      axes_type v;
      for (int k = 0; k < AXES; k++) v[k] = rand_axis();
      send_request(FUNC_PUSH, stamp, v);
   endtask

   task automatic plain_request(logic [1:0] func, logic [TIME_W-1:0] stamp);
      axes_type v;
      for (int k = 0; k < AXES; k++) v[k] = $urandom;
      send_request(func, stamp, v);
   endtask

   // Receiver: random stalls on rsp_tready, check at the rising edge.
   initial begin
      @(negedge clock);
      forever begin
         rsp_tready <= ($urandom_range(0, 3) != 0) ? 1'b1 : (gap_len() == 0);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_response(rsp_tuser, rsp_tdata);
         @(negedge clock);
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 900000) begin
         $display("FAIL timestamped_sample_linear_interp_unit");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      int unsigned   sel;
      logic [TIME_W-1:0] lo_t, hi_t;
      board.reset_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty, single sample, extremes, duplicates, ignored code.
      plain_request(FUNC_QUERY, '0);
      push_sample('0);
      plain_request(FUNC_QUERY, '0);
      plain_request(FUNC_QUERY, 48'd5);
      push_sample(48'd100);
      push_sample(48'd100);
      push_sample(48'd300);
      plain_request(FUNC_QUERY, '0);
      plain_request(FUNC_QUERY, 48'd100);
      plain_request(FUNC_QUERY, 48'd101);
      plain_request(FUNC_QUERY, 48'd299);
      plain_request(FUNC_QUERY, 48'd300);
      plain_request(FUNC_QUERY, 48'd301);
      plain_request(2'd3, 48'd150);
      plain_request(FUNC_QUERY, 48'd200);
      push_sample({TIME_W{1'b1}});
      plain_request(FUNC_QUERY, {TIME_W{1'b1}});
      plain_request(FUNC_QUERY, 48'h8000_0000_0000);
      // Unsorted times reach the reversed-bracket cases.
      push_sample(48'd50);
      plain_request(FUNC_QUERY, 48'd60);
      plain_request(FUNC_QUERY, 48'd250);
      plain_request(FUNC_CLEAR, '0);
      plain_request(FUNC_QUERY, 48'd50);

      // Random: mostly ordered pushes and in-span queries, some noise.
      now_us = TIME_W'($urandom_range(0, 1000));
      while (requests < 1550) begin
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            now_us = now_us + (($urandom_range(0, 9) == 0) ? 48'd0 :
                     (($urandom_range(0, 19) == 0) ? {$urandom, 16'h0} & 48'h0FFF_FFFF_FFFF
                                                   : 48'($urandom_range(1, 5000))));
            push_sample(($urandom_range(0, 60) == 0) ? TIME_W'({$urandom, $urandom})
                                                     : now_us);
         end else if (sel < 92) begin
            lo_t = board.count ? board.stamp_ring[board.slot(0)] : '0;
            hi_t = board.count ? board.stamp_ring[board.slot(board.count - 1)] : '0;
            if ($urandom_range(0, 9) == 0)
               plain_request(FUNC_QUERY, TIME_W'({$urandom, $urandom}));
            else if (hi_t > lo_t)
               plain_request(FUNC_QUERY,
                             TIME_W'(lo_t + ({$urandom, $urandom} % (hi_t - lo_t + 1))));
            else plain_request(FUNC_QUERY,
                               TIME_W'(hi_t + TIME_W'($urandom_range(0, 2)) - 48'd1));
         end else if (sel < 95) begin
            plain_request(FUNC_CLEAR, TIME_W'({$urandom, $urandom}));
            now_us = TIME_W'($urandom_range(0, 1000));
         end else if (sel < 97) begin
            plain_request(2'd3, TIME_W'({$urandom, $urandom}));
         end else begin
            // Long runs of pushes wrap the ring.
            repeat ($urandom_range(20, 80)) begin
               now_us = now_us + TIME_W'($urandom_range(0, 300));
               push_sample(now_us);
            end
         end
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // End of run.
   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses.", requests, board.checked);
      $display("Interpolated %0d, exact %0d, too few %0d, outside span %0d.",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.status_seen[3]);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS timestamped_sample_linear_interp_unit");
      else
         $display("FAIL timestamped_sample_linear_interp_unit");
      $finish;
   end
endmodule
